/* rtl/core/psg_pkg.sv */
// Shared types and constants of the pulse/saw sound generator.
package psg_pkg;

   localparam int STEP_W      = 24;
   localparam int SHIFT_W     = 4;
   localparam int CHAN_W      = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int PHASE_W     = 32;
   localparam int CYC_W       = 33;
   localparam int SPEED_W     = 29;
   localparam int SUM_W       = 24;
   localparam int CNT_W       = 13;
   localparam int LEVEL_W     = 13;
   localparam int DIV_CNT_W   = 5;

   localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;
   localparam logic [SPEED_W-1:0] PULSE_MIN_SPEED = 29'd4096;
   localparam logic [SPEED_W-1:0] SAW_MIN_SPEED   = 29'd524288;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAW_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_SH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CH_ENABLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CH_MUTE    = 3'd4;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [1:0] CH_PULSE0 = 2'd0;
   localparam logic [1:0] CH_PULSE1 = 2'd1;
   localparam logic [1:0] CH_SAW    = 2'd2;

   localparam logic [1:0] REG_CTRL    = 2'd0;
   localparam logic [1:0] REG_PER_LO  = 2'd1;
   localparam logic [1:0] REG_PER_HI  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STEP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/psg_req_if.sv */
// Input channel: register write or sample request.
interface psg_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [1:0] channel;
   logic [1:0] reg_index;
   logic [7:0] write_value;

   modport source (output valid, cmd, channel, reg_index, write_value, input ready);
   modport sink   (input valid, cmd, channel, reg_index, write_value, output ready);
endinterface

/* rtl/core/psg_rsp_if.sv */
// Result channel: mixed sample and per-channel levels.
interface psg_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] mix_sample;
   logic [11:0] pulse0_level;
   logic [11:0] pulse1_level;
   logic [12:0] saw_level;

   modport source (output valid, mix_sample, pulse0_level, pulse1_level, saw_level,
                   input ready);
   modport sink   (input valid, mix_sample, pulse0_level, pulse1_level, saw_level,
                   output ready);
endinterface

/* rtl/core/pulse_saw_sound_generator_unit.sv */
// Top level: two pulse channels and one saw channel, averaged per output sample.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | cmd, channel, reg_index, write_value
//  rsp     | out | valid/ready      | mix_sample, pulse0/pulse1/saw_level
//  csr     | in  | csr_wr_en only   | csr_index, csr_wr_data
//
// A write item is taken in the idle state. A sample item passes, per live channel,
// through a load state, the substep walk over the substeps crossed this sample
// and the divider; a done state then posts the result.
// A channel below its minimum speed spends only its load state.
// One shared adder walks the substeps; one restoring divider forms each average.
// Synchronous reset clears channel registers and walk state and sets CSR defaults.
// A result waiting on rsp does not block new writes; the next sample waits there.
module pulse_saw_sound_generator_unit
   import psg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   psg_req_if.sink               req_bus,
   psg_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [STEP_W-1:0]  pulse_step_ff, saw_step_ff;
   logic [SHIFT_W-1:0] level_shift_ff;
   logic [CHAN_W-1:0]  chan_en_ff, chan_mute_ff;

   logic [7:0]         regs_ff [3][3];
   logic [7:0]         regs_in [3][3];
   logic [SPEED_W-1:0] speed_ff [3];
   logic [SPEED_W-1:0] speed_in [3];
   logic [2:0]         dirty_ff, dirty_in;
   logic [PHASE_W-1:0] phase_ff [3];
   logic [PHASE_W-1:0] phase_in [3];
   logic [6:0]         sub_ff [3];
   logic [6:0]         sub_in [3];
   logic [3:0]         pos_ff [3];
   logic [3:0]         pos_in [3];
   logic [8:0]         saw_acc_ff, saw_acc_in;

   logic [1:0]              ch_ff, ch_in;
   logic signed [CYC_W-1:0] cyc_ff, cyc_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [LEVEL_W-1:0]      res_ff [3];
   logic [LEVEL_W-1:0]      res_in [3];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] mix_ff, mix_in;
   logic [11:0] p0_ff, p0_in, p1_ff, p1_in;
   logic [12:0] sw_ff, sw_in;

   // combinational helpers
   logic [SHIFT_W-1:0]      eff_sh;
   logic                    is_saw;
   logic [7:0]              r0, r1, r2;
   logic [12:0]             pp1;
   logic [SPEED_W-1:0]      speed_new, speed_sel;
   logic [4:0]              base_lvl;
   logic [LEVEL_W-1:0]      level;
   logic signed [CYC_W-1:0] phase_ext, speed_ext;
   logic                    more;
   logic [CNT_W:0]          rem_sh;
   logic                    qbit;
   logic [SUM_W-1:0]        quot;
   logic                    silenced;
   logic [3:0]              pos_nx;
   logic [8:0]              acc_nx;
   logic [LEVEL_W-1:0]      m0, m1, m2;
   logic                    req_xfer;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   assign eff_sh    = (level_shift_ff > MAX_SHIFT) ? MAX_SHIFT : level_shift_ff;
   assign is_saw    = (ch_ff == CH_SAW);
   assign r0        = regs_ff[ch_ff][REG_CTRL];
   assign r1        = regs_ff[ch_ff][REG_PER_LO];
   assign r2        = regs_ff[ch_ff][REG_PER_HI];
   assign pp1       = {1'b0, r2[3:0], r1} + 13'd1;
   assign speed_new = is_saw ? {pp1, 16'd0} : {7'd0, pp1, 9'd0};
   assign speed_sel = dirty_ff[ch_ff] ? speed_new : speed_ff[ch_ff];
   assign phase_ext = {phase_ff[ch_ff][PHASE_W-1], phase_ff[ch_ff]};
   assign speed_ext = {4'd0, speed_ff[ch_ff]};

   // pulse is silent through the low duty positions unless bit 7 forces it on
   always_comb begin
      if (is_saw) begin
         base_lvl = saw_acc_ff[7:3];
      end else if (!r0[7] && (pos_ff[ch_ff] <= {1'b0, r0[6:4]})) begin
         base_lvl = 5'd0;
      end else begin
         base_lvl = {1'b0, r0[3:0]};
      end
   end
   assign level = LEVEL_W'(base_lvl) << eff_sh;

   assign more = is_saw ? cyc_ff[CYC_W-1] : (!cyc_ff[CYC_W-1] && (cyc_ff != '0));

   // one restoring divide step
   assign rem_sh   = {rem_ff, sum_ff[SUM_W-1]};
   assign qbit     = (rem_sh >= {1'b0, count_ff});
   assign quot     = {sum_ff[SUM_W-2:0], qbit};
   assign silenced = chan_mute_ff[ch_ff] || !r2[7];

   assign m0 = chan_en_ff[0] ? res_ff[0] : '0;
   assign m1 = chan_en_ff[1] ? res_ff[1] : '0;
   assign m2 = chan_en_ff[2] ? res_ff[2] : '0;

   always_comb begin
      state_in     = state_ff;
      regs_in      = regs_ff;
      speed_in     = speed_ff;
      dirty_in     = dirty_ff;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      pos_in       = pos_ff;
      saw_acc_in   = saw_acc_ff;
      ch_in        = ch_ff;
      cyc_in       = cyc_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mix_in       = mix_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      sw_in        = sw_ff;
      pos_nx       = pos_ff[ch_ff] + 4'd1;
      acc_nx       = saw_acc_ff + {3'd0, regs_ff[CH_SAW][REG_CTRL][5:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_bus.cmd == CMD_SAMPLE) begin
                  ch_in    = CH_PULSE0;
                  state_in = ST_LOAD;
               end else if (req_bus.channel != 2'd3 && req_bus.reg_index != 2'd3) begin
                  regs_in[req_bus.channel][req_bus.reg_index] = req_bus.write_value;
                  if (req_bus.reg_index != REG_CTRL) begin
                     dirty_in[req_bus.channel] = 1'b1;
                  end
               end
            end
         end
         ST_LOAD: begin
            speed_in[ch_ff] = speed_sel;
            dirty_in[ch_ff] = 1'b0;
            sum_in          = '0;
            count_in        = '0;
            if (is_saw) begin
               cyc_in = phase_ext - $signed({3'd0, saw_step_ff, 6'd0});
            end else begin
               cyc_in = phase_ext + $signed({9'd0, pulse_step_ff});
            end
            if (speed_sel < (is_saw ? SAW_MIN_SPEED : PULSE_MIN_SPEED)) begin
               res_in[ch_ff] = '0;
               if (is_saw) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            sum_in   = sum_ff + SUM_W'(level);
            count_in = count_ff + 1'b1;
            if (more) begin
               cyc_in = is_saw ? (cyc_ff + speed_ext) : (cyc_ff - speed_ext);
               if (is_saw) begin
                  if (sub_ff[ch_ff] == 7'd63) begin
                     sub_in[ch_ff] = '0;
                     if (pos_nx == 4'd7) begin
                        pos_in[ch_ff] = '0;
                        saw_acc_in    = '0;
                     end else begin
                        pos_in[ch_ff] = pos_nx;
                        saw_acc_in    = acc_nx;
                     end
                  end else begin
                     sub_in[ch_ff] = sub_ff[ch_ff] + 7'd1;
                  end
               end else begin
                  sub_in[ch_ff] = sub_ff[ch_ff] + 7'd1;
                  if (sub_ff[ch_ff] == 7'd127) begin
                     pos_in[ch_ff] = pos_nx;
                  end
               end
            end else begin
               phase_in[ch_ff] = cyc_ff[PHASE_W-1:0];
               rem_in          = '0;
               div_cnt_in      = '0;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in     = qbit ? CNT_W'(rem_sh - {1'b0, count_ff}) : rem_sh[CNT_W-1:0];
            sum_in     = quot;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               res_in[ch_ff] = silenced ? '0 : quot[LEVEL_W-1:0];
               if (is_saw) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               mix_in       = 14'(m0) + 14'(m1) + 14'(m2);
               p0_in        = m0[11:0];
               p1_in        = m1[11:0];
               sw_in        = m2;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_step_ff  <= 24'd2659739;
         saw_step_ff    <= 24'd1329869;
         level_shift_ff <= 4'd8;
         chan_en_ff     <= 3'd7;
         chan_mute_ff   <= 3'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PULSE_STEP: pulse_step_ff  <= csr_wr_data[STEP_W-1:0];
            CSR_SAW_STEP:   saw_step_ff    <= csr_wr_data[STEP_W-1:0];
            CSR_LEVEL_SH:   level_shift_ff <= csr_wr_data[SHIFT_W-1:0];
            CSR_CH_ENABLE:  chan_en_ff     <= csr_wr_data[CHAN_W-1:0];
            CSR_CH_MUTE:    chan_mute_ff   <= csr_wr_data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               regs_ff[c][r] <= '0;
            end
            speed_ff[c] <= '0;
            phase_ff[c] <= '0;
            sub_ff[c]   <= '0;
            pos_ff[c]   <= '0;
         end
         dirty_ff     <= '0;
         saw_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         speed_ff     <= speed_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         pos_ff       <= pos_in;
         dirty_ff     <= dirty_in;
         saw_acc_ff   <= saw_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      cyc_ff     <= cyc_in;
      sum_ff     <= sum_in;
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      res_ff     <= res_in;
      mix_ff     <= mix_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      sw_ff      <= sw_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mix_sample   = mix_ff;
   assign rsp_bus.pulse0_level = p0_ff;
   assign rsp_bus.pulse1_level = p1_ff;
   assign rsp_bus.saw_level    = sw_ff;

   // divisor is at least one and the partial remainder stays below it
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> count_ff != '0)
      else $error("divide with zero substep count");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < count_ff)
      else $error("divider remainder out of range");

   a_saw_pos: assert property (@(posedge clock) disable iff (reset)
      pos_ff[CH_SAW] < 4'd7)
      else $error("saw step position past its wrap");

   a_pulse_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && ch_ff != CH_SAW) |->
      (phase_ff[ch_ff][PHASE_W-1] || phase_ff[ch_ff] == '0))
      else $error("pulse phase left positive after substep walk");

endmodule
